/* sv/kfi_pkg.sv */
package kfi_pkg;

  localparam logic       OPC_WRITE       = 1'b0;
  localparam logic       OPC_TICK        = 1'b1;
  localparam logic [2:0] MODE_LINEAR     = 3'd1;
  localparam logic [2:0] MODE_COSINE     = 3'd2;
  localparam logic [2:0] MODE_RESET      = 3'd1;
  localparam logic [6:0] KEY_COUNT_RESET = 7'd2;
  localparam logic [16:0] T_ONE          = 17'd65536;
  localparam int unsigned DIV_STEPS      = 16;
  localparam int unsigned CNT_W          = $clog2(DIV_STEPS);
  localparam logic [63:0] PI_Q30         = 64'd3373259426;
  localparam logic [63:0] ONE_Q30        = 64'd1 << 30;

  typedef enum logic [4:0] {
    S_IDLE, S_TICK, S_ONE, S_ST0, S_ST1, S_ADD, S_DIR,
    S_FWD, S_FLD, S_FTO, S_BWD, S_BLD, S_BTO,
    S_T, S_DIV, S_W, S_M, S_S, S_B, S_BS, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE, OP_LATCH, OP_LD_ONE, OP_LD_SEG0, OP_LD_START, OP_ADD,
    OP_SET_END, OP_FWD_ADV, OP_LD_SEG, OP_LD_SEG_END, OP_LD_TO, OP_BWD_DEC,
    OP_LD_BWD, OP_CLAMP, OP_T_DIRECT, OP_DIV_INIT, OP_DIV_STEP, OP_SEL_W,
    OP_MUL_A, OP_SUM_A, OP_RES_FROM, OP_MUL_B, OP_SUM_B, OP_FINISH
  } op_e;

  typedef enum logic [1:0] {RD_ZERO, RD_ONE, RD_KP1, RD_KPM1} rdsel_e;

  typedef enum logic [1:0] {KIND_WRITE, KIND_NONE, KIND_ONE, KIND_TICK} kind_e;

  typedef struct packed {
    op_e    op;
    rdsel_e rd;
    kind_e  kind;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic delta_neg;
    logic lt_neg;
    logic kp_zero;
    logic fwd_more;
    logic kp_last;
    logic started;
    logic t_direct;
    logic interp;
    logic blend_on;
  } stat_t;

  // sin^2 entry for the lower half of the table, Q2.30 taylor series
  function automatic logic [16:0] cos_half(input int unsigned i, input int unsigned bits);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] f;
    a    = (PI_Q30 * 64'(i)) >> (bits + 1);
    a2   = (a * a) >> 30;
    term = ONE_Q30 - a2 / 64'd72;
    term = ONE_Q30 - ((a2 * term) >> 30) / 64'd42;
    term = ONE_Q30 - ((a2 * term) >> 30) / 64'd20;
    term = ONE_Q30 - ((a2 * term) >> 30) / 64'd6;
    s    = (a * term) >> 30;
    f    = (s * s) >> 30;
    return 17'((f + 64'd8192) >> 14);
  endfunction

  function automatic logic [16:0] cos_entry(input int unsigned i, input int unsigned bits);
    int unsigned n;
    n = 1 << bits;
    if (2 * i <= n) begin
      return cos_half(i, bits);
    end
    return T_ONE - cos_half(n - i, bits);
  endfunction

endpackage

/* sv/kfi_ctrl.sv */
module kfi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  input  logic            out_free_i,
  input  kfi_pkg::stat_t  stat_i,
  output kfi_pkg::cmd_t   cmd_o,
  output logic            in_stall_o,
  output logic            res_load_o
);

  kfi_pkg::state_e state_q, state_d;
  kfi_pkg::kind_e  kind_q, kind_d;
  logic [kfi_pkg::CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kfi_pkg::S_IDLE;
      kind_q  <= kfi_pkg::KIND_WRITE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cnt_d      = cnt_q;
    cmd_o.op   = kfi_pkg::OP_NONE;
    cmd_o.rd   = kfi_pkg::RD_ZERO;
    cmd_o.kind = kind_q;
    in_stall_o = 1'b1;
    res_load_o = 1'b0;
    unique case (state_q)
      kfi_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_op_i == kfi_pkg::OPC_WRITE) begin
            cmd_o.op = kfi_pkg::OP_WRITE;
            kind_d   = kfi_pkg::KIND_WRITE;
            state_d  = kfi_pkg::S_DONE;
          end else begin
            cmd_o.op = kfi_pkg::OP_LATCH;
            state_d  = kfi_pkg::S_TICK;
          end
        end
      end
      kfi_pkg::S_TICK: begin
        if (stat_i.n_zero) begin
          kind_d  = kfi_pkg::KIND_NONE;
          state_d = kfi_pkg::S_DONE;
        end else if (stat_i.n_one) begin
          kind_d   = kfi_pkg::KIND_ONE;
          cmd_o.rd = kfi_pkg::RD_ZERO;
          state_d  = kfi_pkg::S_ONE;
        end else if (!stat_i.started) begin
          kind_d   = kfi_pkg::KIND_TICK;
          cmd_o.rd = kfi_pkg::RD_ZERO;
          state_d  = kfi_pkg::S_ST0;
        end else begin
          kind_d  = kfi_pkg::KIND_TICK;
          state_d = kfi_pkg::S_ADD;
        end
      end
      kfi_pkg::S_ONE: begin
        cmd_o.op = kfi_pkg::OP_LD_ONE;
        state_d  = kfi_pkg::S_DONE;
      end
      kfi_pkg::S_ST0: begin
        cmd_o.op = kfi_pkg::OP_LD_SEG0;
        cmd_o.rd = kfi_pkg::RD_ONE;
        state_d  = kfi_pkg::S_ST1;
      end
      kfi_pkg::S_ST1: begin
        cmd_o.op = kfi_pkg::OP_LD_START;
        state_d  = kfi_pkg::S_ADD;
      end
      kfi_pkg::S_ADD: begin
        cmd_o.op = kfi_pkg::OP_ADD;
        state_d  = kfi_pkg::S_DIR;
      end
      kfi_pkg::S_DIR: begin
        if (!stat_i.delta_neg) begin
          state_d = kfi_pkg::S_FWD;
        end else if (stat_i.lt_neg && !stat_i.kp_zero) begin
          state_d = kfi_pkg::S_BWD;
        end else begin
          state_d = kfi_pkg::S_T;
        end
      end
      kfi_pkg::S_FWD: begin
        if (!stat_i.fwd_more) begin
          state_d = kfi_pkg::S_T;
        end else if (stat_i.kp_last) begin
          cmd_o.op = kfi_pkg::OP_SET_END;
          state_d  = kfi_pkg::S_T;
        end else begin
          cmd_o.op = kfi_pkg::OP_FWD_ADV;
          cmd_o.rd = kfi_pkg::RD_KP1;
          state_d  = kfi_pkg::S_FLD;
        end
      end
      kfi_pkg::S_FLD: begin
        if (stat_i.kp_last) begin
          cmd_o.op = kfi_pkg::OP_LD_SEG_END;
          state_d  = kfi_pkg::S_FWD;
        end else begin
          cmd_o.op = kfi_pkg::OP_LD_SEG;
          cmd_o.rd = kfi_pkg::RD_KP1;
          state_d  = kfi_pkg::S_FTO;
        end
      end
      kfi_pkg::S_FTO: begin
        cmd_o.op = kfi_pkg::OP_LD_TO;
        state_d  = kfi_pkg::S_FWD;
      end
      kfi_pkg::S_BWD: begin
        if (stat_i.lt_neg && !stat_i.kp_zero) begin
          cmd_o.op = kfi_pkg::OP_BWD_DEC;
          cmd_o.rd = kfi_pkg::RD_KPM1;
          state_d  = kfi_pkg::S_BLD;
        end else begin
          cmd_o.op = kfi_pkg::OP_CLAMP;
          state_d  = kfi_pkg::S_T;
        end
      end
      kfi_pkg::S_BLD: begin
        cmd_o.op = kfi_pkg::OP_LD_BWD;
        cmd_o.rd = kfi_pkg::RD_KP1;
        state_d  = kfi_pkg::S_BTO;
      end
      kfi_pkg::S_BTO: begin
        cmd_o.op = kfi_pkg::OP_LD_TO;
        state_d  = kfi_pkg::S_BWD;
      end
      kfi_pkg::S_T: begin
        if (stat_i.t_direct) begin
          cmd_o.op = kfi_pkg::OP_T_DIRECT;
          state_d  = kfi_pkg::S_W;
        end else begin
          cmd_o.op = kfi_pkg::OP_DIV_INIT;
          cnt_d    = '0;
          state_d  = kfi_pkg::S_DIV;
        end
      end
      kfi_pkg::S_DIV: begin
        cmd_o.op = kfi_pkg::OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == kfi_pkg::CNT_W'(kfi_pkg::DIV_STEPS - 1)) begin
          state_d = kfi_pkg::S_W;
        end
      end
      kfi_pkg::S_W: begin
        if (stat_i.interp) begin
          cmd_o.op = kfi_pkg::OP_SEL_W;
          state_d  = kfi_pkg::S_M;
        end else begin
          cmd_o.op = kfi_pkg::OP_RES_FROM;
          state_d  = kfi_pkg::S_B;
        end
      end
      kfi_pkg::S_M: begin
        cmd_o.op = kfi_pkg::OP_MUL_A;
        state_d  = kfi_pkg::S_S;
      end
      kfi_pkg::S_S: begin
        cmd_o.op = kfi_pkg::OP_SUM_A;
        state_d  = kfi_pkg::S_B;
      end
      kfi_pkg::S_B: begin
        if (stat_i.blend_on) begin
          cmd_o.op = kfi_pkg::OP_MUL_B;
          state_d  = kfi_pkg::S_BS;
        end else begin
          state_d = kfi_pkg::S_DONE;
        end
      end
      kfi_pkg::S_BS: begin
        cmd_o.op = kfi_pkg::OP_SUM_B;
        state_d  = kfi_pkg::S_DONE;
      end
      kfi_pkg::S_DONE: begin
        if (out_free_i) begin
          cmd_o.op   = kfi_pkg::OP_FINISH;
          res_load_o = 1'b1;
          state_d    = kfi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kfi_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* sv/kfi_dp.sv */
module kfi_dp #(
  parameter int unsigned MAX_KEYS       = 64,
  parameter int unsigned COS_TABLE_BITS = 8,
  localparam int unsigned KPW           = $clog2(MAX_KEYS),
  localparam int unsigned NW            = KPW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kfi_pkg::cmd_t       cmd_i,
  output kfi_pkg::stat_t      stat_o,
  input  logic [NW-1:0]       n_i,
  input  logic [5:0]          key_index_i,
  input  logic [30:0]         key_length_i,
  input  logic [2:0]          key_mode_i,
  input  logic signed [31:0]  key_value_i,
  input  logic signed [31:0]  delta_time_i,
  input  logic [16:0]         blend_i,
  output logic signed [31:0]  out_value_o,
  output logic                out_valid_o,
  output logic [5:0]          current_key_o,
  output logic                at_end_o
);

  localparam int unsigned COS_N = 1 << COS_TABLE_BITS;

  logic [65:0] mem [MAX_KEYS];
  logic [65:0] rd_q;
  logic [KPW-1:0] ra;

  logic [KPW-1:0]     kp_q;
  logic signed [31:0] lt_q;
  logic [30:0]        seglen_q;
  logic [2:0]         mode_q;
  logic signed [31:0] from_q, to_q, last_q;
  logic               ended_q, started_q;

  logic signed [31:0] delta_q, res_q;
  logic [16:0]        blend_q, t_q, w_q;
  logic [31:0]        rem_q;
  logic signed [50:0] prod_q;

  logic [16:0] cos_rom [COS_N+1];
  logic [COS_TABLE_BITS:0] cidx;

  logic [30:0]        rd_len;
  logic [2:0]         rd_mode;
  logic signed [31:0] rd_val;

  logic signed [32:0] add_dt, sub_len, add_len, diff;
  logic signed [50:0] prod_d, prod_sh;
  logic [16:0]        mul_w;
  logic [32:0]        r2;
  logic               r_ge;

  for (genvar g = 0; g <= COS_N; g++) begin : g_cos
    assign cos_rom[g] = kfi_pkg::cos_entry(g, COS_TABLE_BITS);
  end

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  assign rd_len  = rd_q[65:35];
  assign rd_mode = rd_q[34:32];
  assign rd_val  = rd_q[31:0];
  assign cidx    = t_q[16 -: (COS_TABLE_BITS + 1)];

  always_comb begin
    case (cmd_i.rd)
      kfi_pkg::RD_ONE:  ra = KPW'(1);
      kfi_pkg::RD_KP1:  ra = kp_q + 1'b1;
      kfi_pkg::RD_KPM1: ra = kp_q - 1'b1;
      default:          ra = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == kfi_pkg::OP_WRITE && 32'(key_index_i) < MAX_KEYS) begin
      mem[KPW'(key_index_i)] <= {key_length_i, key_mode_i, key_value_i};
    end
    rd_q <= mem[ra];
  end

  assign add_dt  = 33'(lt_q) + 33'(delta_q);
  assign sub_len = 33'(lt_q) - $signed({2'b00, seglen_q});
  assign add_len = 33'(lt_q) + $signed({2'b00, rd_len});
  assign diff    = (cmd_i.op == kfi_pkg::OP_MUL_A) ? 33'(to_q) - 33'(from_q)
                                                   : 33'(res_q) - 33'(last_q);
  assign mul_w   = (cmd_i.op == kfi_pkg::OP_MUL_A) ? w_q : blend_q;
  assign prod_d  = 51'(diff * $signed({1'b0, mul_w}));
  assign prod_sh = prod_q >>> 16;
  assign r2      = {rem_q, 1'b0};
  assign r_ge    = r2 >= {2'b00, seglen_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= '0;
      lt_q      <= '0;
      seglen_q  <= '0;
      mode_q    <= kfi_pkg::MODE_RESET;
      from_q    <= '0;
      to_q      <= '0;
      ended_q   <= 1'b0;
      started_q <= 1'b0;
      last_q    <= '0;
    end else begin
      case (cmd_i.op)
        kfi_pkg::OP_WRITE: begin
          kp_q      <= '0;
          lt_q      <= '0;
          ended_q   <= 1'b0;
          started_q <= 1'b0;
        end
        kfi_pkg::OP_LD_SEG0: begin
          from_q   <= rd_val;
          seglen_q <= rd_len;
          mode_q   <= rd_mode;
        end
        kfi_pkg::OP_LD_START: begin
          to_q      <= rd_val;
          started_q <= 1'b1;
          ended_q   <= 1'b0;
        end
        kfi_pkg::OP_ADD:     lt_q    <= sat32(add_dt);
        kfi_pkg::OP_SET_END: ended_q <= 1'b1;
        kfi_pkg::OP_FWD_ADV: begin
          lt_q   <= sat32(sub_len);
          kp_q   <= kp_q + 1'b1;
          from_q <= to_q;
        end
        kfi_pkg::OP_LD_SEG: begin
          seglen_q <= rd_len;
          mode_q   <= rd_mode;
        end
        kfi_pkg::OP_LD_SEG_END: begin
          seglen_q <= rd_len;
          mode_q   <= rd_mode;
          ended_q  <= 1'b1;
        end
        kfi_pkg::OP_LD_TO:   to_q <= rd_val;
        kfi_pkg::OP_BWD_DEC: kp_q <= kp_q - 1'b1;
        kfi_pkg::OP_LD_BWD: begin
          lt_q     <= sat32(add_len);
          from_q   <= rd_val;
          seglen_q <= rd_len;
          mode_q   <= rd_mode;
          ended_q  <= 1'b0;
        end
        kfi_pkg::OP_CLAMP: begin
          if (lt_q[31]) begin
            lt_q <= '0;
          end
        end
        kfi_pkg::OP_FINISH: begin
          if (cmd_i.kind == kfi_pkg::KIND_ONE || cmd_i.kind == kfi_pkg::KIND_TICK) begin
            last_q <= res_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op) inside
      kfi_pkg::OP_LATCH: begin
        delta_q <= delta_time_i;
        blend_q <= blend_i;
      end
      kfi_pkg::OP_LD_ONE: res_q <= rd_val;
      kfi_pkg::OP_T_DIRECT: begin
        if (ended_q || (seglen_q != '0 && (lt_q[31] || lt_q == 0))) begin
          t_q <= '0;
        end else begin
          t_q <= kfi_pkg::T_ONE;
        end
      end
      kfi_pkg::OP_DIV_INIT: begin
        rem_q <= lt_q;
        t_q   <= '0;
      end
      kfi_pkg::OP_DIV_STEP: begin
        rem_q <= r_ge ? 32'(r2 - {2'b00, seglen_q}) : r2[31:0];
        t_q   <= {t_q[15:0], r_ge};
      end
      kfi_pkg::OP_SEL_W:    w_q   <= (mode_q == kfi_pkg::MODE_COSINE) ? cos_rom[cidx] : t_q;
      kfi_pkg::OP_MUL_A,
      kfi_pkg::OP_MUL_B:    prod_q <= prod_d;
      kfi_pkg::OP_SUM_A:    res_q <= from_q + prod_sh[31:0];
      kfi_pkg::OP_RES_FROM: res_q <= from_q;
      kfi_pkg::OP_SUM_B:    res_q <= last_q + prod_sh[31:0];
      default: ;
    endcase
  end

  always_comb begin
    stat_o.n_zero    = n_i == '0;
    stat_o.n_one     = n_i == NW'(1);
    stat_o.delta_neg = delta_q[31];
    stat_o.lt_neg    = lt_q[31];
    stat_o.kp_zero   = kp_q == '0;
    stat_o.fwd_more  = !ended_q && ($signed({lt_q[31], lt_q}) > $signed({2'b00, seglen_q}));
    stat_o.kp_last   = ({1'b0, kp_q} + NW'(1)) >= n_i;
    stat_o.started   = started_q;
    stat_o.t_direct  = ended_q || seglen_q == '0 || lt_q[31] || lt_q == 0 ||
                       32'(lt_q) >= {1'b0, seglen_q};
    stat_o.interp    = mode_q == kfi_pkg::MODE_LINEAR || mode_q == kfi_pkg::MODE_COSINE;
    stat_o.blend_on  = blend_q < kfi_pkg::T_ONE;
  end

  always_comb begin
    case (cmd_i.kind)
      kfi_pkg::KIND_WRITE: begin
        out_value_o   = last_q;
        out_valid_o   = 1'b0;
        current_key_o = '0;
        at_end_o      = 1'b0;
      end
      kfi_pkg::KIND_NONE: begin
        out_value_o   = last_q;
        out_valid_o   = 1'b0;
        current_key_o = 6'(kp_q);
        at_end_o      = ended_q;
      end
      kfi_pkg::KIND_ONE: begin
        out_value_o   = res_q;
        out_valid_o   = 1'b1;
        current_key_o = 6'(kp_q);
        at_end_o      = 1'b1;
      end
      default: begin
        out_value_o   = res_q;
        out_valid_o   = 1'b1;
        current_key_o = 6'(kp_q);
        at_end_o      = ended_q;
      end
    endcase
  end

endmodule

/* sv/keyframe_interpolator.sv */
// keyframe playback engine, Q16.16 fixed point
// input channel: in_valid_i / in_stall_o with op_i and the key or tick fields;
//   op 0 stores one key in the key memory and restarts playback at key 0,
//   op 1 advances local time by delta_time_i and produces a value
// result channel: res_valid_o / res_stall_i carrying out_value_o, out_valid_o,
//   current_key_o and at_end_o; every input transaction gives one result
// config: cfg_we_i writes key_count from cfg_data_i; the user must write it only while
//   idle, as the block itself does not enforce it
// a tick's time is set by the 16-step restoring divider for t, the keys walked,
//   the single shared 33x17 multiplier and the key memory's one read port
// one transaction is in work at a time; the next is taken once the result
//   sits in the output register, so a stalled receiver holds only that register
// reset: key_count 2, playback at key 0, previous output 0; the key memory
//   holds no defined contents until written
module keyframe_interpolator #(
  parameter int unsigned MAX_KEYS       = 64,
  parameter int unsigned COS_TABLE_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [5:0]         key_index_i,
  input  logic [30:0]        key_length_i,
  input  logic [2:0]         key_mode_i,
  input  logic signed [31:0] key_value_i,
  input  logic signed [31:0] delta_time_i,
  input  logic [16:0]        blend_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic signed [31:0] out_value_o,
  output logic               out_valid_o,
  output logic [5:0]         current_key_o,
  output logic               at_end_o
);

  localparam int unsigned NW = $clog2(MAX_KEYS) + 1;

  logic [6:0]    key_count_q;
  logic [NW-1:0] n;

  kfi_pkg::cmd_t  cmd;
  kfi_pkg::stat_t stat;
  logic res_load, out_free, res_valid_q;

  logic signed [31:0] dp_value;
  logic               dp_valid, dp_end;
  logic [5:0]         dp_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= kfi_pkg::KEY_COUNT_RESET;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_data_i;
    end
  end

  assign n = (32'(key_count_q) >= MAX_KEYS) ? NW'(MAX_KEYS) : NW'(key_count_q);

  assign out_free = !res_valid_q || !res_stall_i;

  kfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (op_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .res_load_o (res_load)
  );

  kfi_dp #(
    .MAX_KEYS       (MAX_KEYS),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .n_i           (n),
    .key_index_i   (key_index_i),
    .key_length_i  (key_length_i),
    .key_mode_i    (key_mode_i),
    .key_value_i   (key_value_i),
    .delta_time_i  (delta_time_i),
    .blend_i       (blend_i),
    .out_value_o   (dp_value),
    .out_valid_o   (dp_valid),
    .current_key_o (dp_key),
    .at_end_o      (dp_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_value_o   <= dp_value;
      out_valid_o   <= dp_valid;
      current_key_o <= dp_key;
      at_end_o      <= dp_end;
    end
  end

  assign res_valid_o = res_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block not busy after an accepted transaction");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_load && res_valid_q && res_stall_i))
    else $error("held result overwritten");

  a_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> in_stall_o)
    else $error("result loaded while accepting input");

endmodule

/* verif/keyframe_interpolator_tb.sv */
module keyframe_interpolator_tb;

  localparam logic [2:0] MODE_HOLD   = 3'd0;
  localparam logic [2:0] MODE_BEZIER = 3'd4;
  localparam logic [2:0] MODE_SPARE  = 3'd7;
  localparam int unsigned NKEYS      = 64;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic               op;
    logic [5:0]         idx;
    logic [30:0]        len;
    logic [2:0]         mode;
    logic signed [31:0] val;
    logic signed [31:0] delta;
    logic [16:0]        blend;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               valid;
    logic [5:0]         key;
    logic               at_end;
  } result_t;

  typedef struct packed {
    logic       cfg_on;
    logic [6:0] cfg;
    item_t      it;
    logic       typed;
    result_t    res;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [6:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               op_i = kfi_pkg::OPC_WRITE;
  logic [5:0]         key_index_i = '0;
  logic [30:0]        key_length_i = '0;
  logic [2:0]         key_mode_i = '0;
  logic signed [31:0] key_value_i = '0;
  logic signed [31:0] delta_time_i = '0;
  logic [16:0]        blend_i = '0;
  logic               res_valid_o;
  logic               res_stall_i = 1'b0;
  logic signed [31:0] out_value_o;
  logic               out_valid_o;
  logic [5:0]         current_key_o;
  logic               at_end_o;

  keyframe_interpolator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int unsigned        key_cnt = kfi_pkg::KEY_COUNT_RESET;
  logic [30:0]        len_mem [NKEYS];
  logic [2:0]         mode_mem [NKEYS];
  int                 val_mem [NKEYS];
  int unsigned        kp = 0;
  int                 lt = 0;
  longint             seg_len = 0;
  logic [2:0]         seg_mode = kfi_pkg::MODE_RESET;
  int                 from_v = 0;
  int                 to_v = 0;
  bit                 ended_f = 0;
  bit                 started_f = 0;
  int                 prev_out = 0;
  int unsigned        sin2_tab [257];

  result_t            expq [$];
  int                 errors = 0;
  int unsigned        send_pct = 0;
  int unsigned        stall_pct = 0;
  int unsigned        idle_cnt = 0;

  function automatic void build_sin2();
    logic [63:0] a, a2, term, s, f;
    for (int i = 0; i <= 128; i++) begin
      a = (kfi_pkg::PI_Q30 * 64'(i)) / 64'd512;
      a2 = (a * a) >> 30;
      term = kfi_pkg::ONE_Q30 - a2 / 64'd72;
      term = kfi_pkg::ONE_Q30 - ((a2 * term) >> 30) / 64'd42;
      term = kfi_pkg::ONE_Q30 - ((a2 * term) >> 30) / 64'd20;
      term = kfi_pkg::ONE_Q30 - ((a2 * term) >> 30) / 64'd6;
      s = (a * term) >> 30;
      f = (s * s) >> 30;
      sin2_tab[i] = int'((f + 64'd8192) >> 14);
    end
    for (int i = 129; i <= 256; i++) sin2_tab[i] = 65536 - sin2_tab[256 - i];
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int mix(int a, int b, int unsigned w);
    longint d;
    d = longint'(b) - longint'(a);
    return int'(longint'(a) + ((d * longint'(w)) >>> 16));
  endfunction

  function automatic result_t play_item(item_t it);
    result_t     r;
    int unsigned n;
    longint      dl;
    int          v;
    int unsigned t;
    n = key_cnt < NKEYS ? key_cnt : NKEYS;
    dl = longint'(it.delta);
    if (it.op == kfi_pkg::OPC_WRITE) begin
      len_mem[it.idx] = it.len;
      mode_mem[it.idx] = it.mode;
      val_mem[it.idx] = it.val;
      kp = 0;
      lt = 0;
      ended_f = 0;
      started_f = 0;
      r = '{prev_out, 1'b0, 6'd0, 1'b0};
      return r;
    end
    if (n == 0) begin
      r = '{prev_out, 1'b0, kp[5:0], ended_f};
      return r;
    end
    if (n == 1) begin
      prev_out = val_mem[0];
      r = '{prev_out, 1'b1, kp[5:0], 1'b1};
      return r;
    end
    if (!started_f) begin
      from_v = val_mem[0];
      seg_len = len_mem[0];
      seg_mode = mode_mem[0];
      to_v = val_mem[1];
      started_f = 1;
      ended_f = 0;
    end
    lt = sat32(longint'(lt) + dl);
    if (dl < 0) begin
      if (lt < 0 && kp != 0) begin
        while (lt < 0 && kp != 0) begin
          kp--;
          lt = sat32(longint'(lt) + longint'(len_mem[kp]));
          from_v = val_mem[kp];
          seg_len = len_mem[kp];
          seg_mode = mode_mem[kp];
          to_v = val_mem[kp + 1];
          ended_f = 0;
        end
        if (lt < 0) lt = 0;
      end
    end else begin
      while (!ended_f && longint'(lt) > seg_len) begin
        if (kp + 1 >= n) begin
          ended_f = 1;
          break;
        end
        lt = sat32(longint'(lt) - longint'(len_mem[kp]));
        kp++;
        seg_mode = mode_mem[kp];
        seg_len = len_mem[kp];
        from_v = to_v;
        if (kp >= n - 1) ended_f = 1;
        else to_v = val_mem[kp + 1];
      end
    end
    if (ended_f) t = 0;
    else if (seg_len == 0) t = 65536;
    else if (lt <= 0) t = 0;
    else if (longint'(lt) >= seg_len) t = 65536;
    else t = int'((longint'(lt) << 16) / seg_len);
    if (seg_mode == kfi_pkg::MODE_LINEAR) v = mix(from_v, to_v, t);
    else if (seg_mode == kfi_pkg::MODE_COSINE) v = mix(from_v, to_v, sin2_tab[t >> 8]);
    else v = from_v;
    if (it.blend < kfi_pkg::T_ONE) v = mix(prev_out, v, it.blend);
    prev_out = v;
    r = '{v, 1'b1, kp[5:0], ended_f};
    return r;
  endfunction

  function automatic item_t key_item(int unsigned idx, logic [30:0] len, logic [2:0] mode,
                                     int val);
    item_t it;
    it = '0;
    it.op = kfi_pkg::OPC_WRITE;
    it.idx = idx[5:0];
    it.len = len;
    it.mode = mode;
    it.val = val;
    return it;
  endfunction

  function automatic item_t tick_item(int delta, int unsigned blend);
    item_t it;
    it = '0;
    it.op = kfi_pkg::OPC_TICK;
    it.delta = delta;
    it.blend = blend[16:0];
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int unsigned r;
    it.op = ($urandom_range(99) < 10) ? kfi_pkg::OPC_WRITE : kfi_pkg::OPC_TICK;
    it.idx = 6'($urandom_range(63));
    r = $urandom_range(9);
    it.len = (r == 0) ? 31'd0 : (r == 1) ? 31'($urandom()) : 31'($urandom_range(1, 'h40000));
    it.mode = 3'($urandom_range(7));
    it.val = $urandom();
    r = $urandom_range(9);
    if (r == 0) it.delta = $urandom();
    else if (r <= 2) it.delta = -int'($urandom_range(0, 'h40000));
    else it.delta = $urandom_range(0, 'h30000);
    r = $urandom_range(9);
    if (r <= 5) it.blend = kfi_pkg::T_ONE;
    else if (r <= 7) it.blend = 17'($urandom_range(65536));
    else if (r == 8) it.blend = 17'($urandom_range(65537, 131071));
    else it.blend = '0;
    return it;
  endfunction

  task automatic send_item(item_t it, bit typed, result_t tres);
    result_t r;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= it.op;
    key_index_i  <= it.idx;
    key_length_i <= it.len;
    key_mode_i   <= it.mode;
    key_value_i  <= it.val;
    delta_time_i <= it.delta;
    blend_i      <= it.blend;
    do @(posedge clk_i); while (in_stall_o);
    r = play_item(it);
    expq.insert(expq.size(), typed ? tres : r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expq.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_cnt = v;
  endtask

  // result side: random stall and in-order compare
  always @(posedge clk_i) begin
    result_t e;
    if (res_valid_o && !res_stall_i) begin
      if (expq.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction value=%h", out_value_o);
      end else begin
        e = expq.pop_front();
        if (out_value_o !== e.value || out_valid_o !== e.valid ||
            current_key_o !== e.key || at_end_o !== e.at_end) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp value=%h valid=%b key=%0d end=%b, got %h %b %0d %b",
                     e.value, e.valid, e.key, e.at_end,
                     out_value_o, out_valid_o, current_key_o, at_end_o);
        end
      end
    end
    res_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt == WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  row_t    rows [$];
  result_t zero_res;

  initial begin
    logic [6:0] cv;
    item_t      it;
    build_sin2();
    zero_res = '0;
    rows.insert(rows.size(), '{1'b1, 7'd0, tick_item('h10000, 65536), 1'b1, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, key_item(0, 31'h10000, kfi_pkg::MODE_LINEAR,
                                                    'h10000), 1'b1, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, key_item(1, 31'h8000, kfi_pkg::MODE_COSINE,
                                                    'h7fffffff), 1'b1, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, key_item(2, 31'd0, MODE_HOLD, 'h80000000), 1'b1,
                               zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, key_item(3, 31'h7fffffff, MODE_BEZIER, -5), 1'b1,
                               zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, key_item(63, 31'h7fffffff, MODE_SPARE, -1), 1'b1,
                               zero_res});
    rows.insert(rows.size(), '{1'b1, 7'd1, tick_item('h4000, 0), 1'b1,
                               result_t'{32'sh10000, 1'b1, 6'd0, 1'b1}});
    rows.insert(rows.size(), '{1'b1, 7'd4, tick_item('h8000, 65536), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h8000, 32768), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h4000, 65536), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h7fffffff, 65536), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h7fffffff, 131071), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h80000000, 0), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item(-1, 65535), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h18000, 65536), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item(0, 65536), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h4000, 65536), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b1, 7'd2, tick_item(-'h8000, 65536), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h30000, 20000), 1'b0, zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, key_item(2, 31'd0, MODE_HOLD, 'h80000000), 1'b0,
                               zero_res});
    rows.insert(rows.size(), '{1'b0, 7'd0, tick_item('h2000, 65536), 1'b0, zero_res});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].cfg_on) write_count(rows[i].cfg);
      send_item(rows[i].it, rows[i].typed, rows[i].res);
    end

    // fill the whole key memory before any wider key count
    for (int i = 0; i < NKEYS; i++) begin
      it = rand_item();
      it.op = kfi_pkg::OPC_WRITE;
      it.idx = 6'(i);
      send_item(it, 1'b0, zero_res);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 47; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 47; end
        default: begin send_pct = 21; stall_pct = 21; end
      endcase
      for (int blk = 0; blk < 6; blk++) begin
        if (ph == 0 && blk < 4) cv = (blk == 0) ? 7'd127 : (blk == 1) ? 7'd0 :
                                     (blk == 2) ? 7'd64 : 7'd1;
        else if ($urandom_range(9) == 0) cv = 7'($urandom_range(1));
        else cv = 7'($urandom_range(2, 127));
        write_count(cv);
        repeat (38) send_item(rand_item(), 1'b0, zero_res);
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
sv/kfi_pkg.sv
sv/kfi_ctrl.sv
sv/kfi_dp.sv
sv/keyframe_interpolator.sv
verif/keyframe_interpolator_tb.sv
